/* rtl/core/tfnu_pkg.sv */
// Shared types and constants for the thermal frame normalize/upscale block.
package tfnu_pkg;
  localparam int GrayMax = 255;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_COORD = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_LOW   = 2'd0,
    REG_HIGH  = 2'd1,
    REG_SCALE = 2'd2,
    REG_MODE  = 2'd3
  } reg_index_t;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_RENDER = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVXY,
    ST_READ,
    ST_NORM,
    ST_ACCUM,
    ST_DIVOUT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic signed [15:0] low_level;
    logic signed [15:0] high_level;
    logic [5:0]         scale_factor;
    logic               interp_mode;
  } cfg_regs_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage

/* rtl/core/tfnu_if.sv */
// Valid/ready channel interfaces for input words, result words and config writes.
interface tfnu_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [5:0]  pixel_index;
  logic signed [15:0] temperature;
  logic [7:0]  out_col;
  logic [7:0]  out_row;
  modport source (output valid, cmd, pixel_index, temperature, out_col, out_row,
                  input ready);
  modport sink (input valid, cmd, pixel_index, temperature, out_col, out_row,
                output ready);
endinterface

interface tfnu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] gray;
  logic [1:0] status;
  modport source (output valid, gray, status, input ready);
  modport sink (input valid, gray, status, output ready);
endinterface

interface tfnu_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/tfnu_div.sv */
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
module tfnu_div #(
  parameter int NumW = 32,
  parameter int DenW = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic            done,
  output logic [NumW-1:0] quot
);
  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] q;
  logic [DenW:0]   rem;
  logic [DenW-1:0] d;
  logic [CntW-1:0] cnt;
  logic            run;
  logic [DenW:0]   trial;

  assign trial = {rem[DenW-1:0], q[NumW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CntW'(NumW);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= num;
      rem <= '0;
      d <= den;
    end else if (run) begin
      if (trial >= {1'b0, d}) begin
        rem <= trial - {1'b0, d};
        q <= {q[NumW-2:0], 1'b1};
      end else begin
        rem <= trial;
        q <= {q[NumW-2:0], 1'b0};
      end
    end
  end

  assign quot = q;
endmodule

/* rtl/core/tfnu_frame_mem.sv */
// Frame sample memory: one write port, one registered read port.
module tfnu_frame_mem #(
  parameter int Depth = 64,
  parameter int AddrW = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AddrW-1:0]  waddr,
  input  logic [15:0]       wdata,
  input  logic [AddrW-1:0]  raddr,
  output logic [15:0]       rdata
);
  logic [15:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* rtl/core/thermal_frame_normalize_upscale_top.sv */
// Top level of the thermal frame normalize/upscale block.
// A load word writes one sample. A render word runs a sequencer around a
// single 32-bit serial divider, one quotient bit per cycle: two coordinate
// divisions by the scale factor, then per source sample one memory read and
// one normalizing division (one or four samples), and for bilinear a final
// division by s*s. Each sample at or below low_level skips its division.
// Range and coordinate errors skip the divider: the sequencer goes straight
// from idle to the output state, which registers the result and sets it
// valid. One item is in flight at a time; the next word is accepted once the
// result is taken.
module thermal_frame_normalize_upscale_top
  import tfnu_pkg::*;
#(
  parameter int FRAME_WIDTH = 8,
  parameter int FRAME_HEIGHT = 8
) (
  input logic clk,
  input logic rst,
  tfnu_in_if.sink   in_ch,
  tfnu_out_if.source out_ch,
  tfnu_cfg_if.sink  cfg_ch
);
  localparam int Depth = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AddrW = $clog2(Depth);
  localparam int ColW = $clog2(FRAME_WIDTH);
  localparam int RowW = $clog2(FRAME_HEIGHT);

  cfg_regs_t cfg;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_level <= 16'sd0;
      cfg.high_level <= 16'sd255;
      cfg.scale_factor <= 6'd1;
      cfg.interp_mode <= 1'b0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (reg_index_t'(cfg_ch.index))
        REG_LOW:   cfg.low_level <= cfg_ch.data;
        REG_HIGH:  cfg.high_level <= cfg_ch.data;
        REG_SCALE: cfg.scale_factor <= cfg_ch.data[5:0];
        REG_MODE:  cfg.interp_mode <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end
  assign cfg_ch.ready = 1'b1;

  logic [5:0]  s;
  logic [16:0] range;
  logic [11:0] ss;
  assign s = (cfg.scale_factor == 6'd0) ? 6'd1 : cfg.scale_factor;
  assign range = 17'($signed(cfg.high_level) - $signed(cfg.low_level));

  // divider
  logic        dv_start, dv_done;
  logic [31:0] dv_num, dv_quot;
  logic [16:0] dv_den;
  tfnu_div #(.NumW(32), .DenW(17)) u_div (
    .clk(clk), .rst(rst), .start(dv_start), .num(dv_num), .den(dv_den),
    .done(dv_done), .quot(dv_quot)
  );

  // memory
  logic             mem_we;
  logic [AddrW-1:0] raddr;
  logic [15:0]      rdata;
  tfnu_frame_mem #(.Depth(Depth), .AddrW(AddrW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(in_ch.pixel_index[AddrW-1:0]),
    .wdata(in_ch.temperature), .raddr(raddr), .rdata(rdata)
  );

  logic accept;
  logic out_busy;
  assign in_ch.ready = (state == ST_IDLE) && !out_busy;
  assign accept = in_ch.valid && in_ch.ready;
  assign mem_we = accept && (in_ch.cmd == CMD_LOAD) &&
                  ({2'b0, in_ch.pixel_index} < 8'(Depth));

  // work registers
  logic [7:0]  x, y;
  logic [7:0]  vx, vy;
  logic [5:0]  fx, fy;
  logic        phase;      // 0: x division, 1: y division
  logic [1:0]  nidx;       // neighbour index
  logic        dv_wait;
  logic [31:0] acc;
  logic [7:0]  gray;
  logic [1:0]  status;
  logic [16:0] dsamp;
  logic [12:0] wgt;

  logic [ColW-1:0] c0, c1, cs;
  logic [RowW-1:0] r0, r1, rs;
  assign c0 = vx[ColW-1:0];
  assign r0 = vy[RowW-1:0];
  assign c1 = (32'(vx) + 1 < FRAME_WIDTH) ? ColW'(vx + 8'd1) : ColW'(FRAME_WIDTH - 1);
  assign r1 = (32'(vy) + 1 < FRAME_HEIGHT) ? RowW'(vy + 8'd1) : RowW'(FRAME_HEIGHT - 1);
  assign cs = nidx[0] ? c1 : c0;
  assign rs = nidx[1] ? r1 : r0;
  assign raddr = AddrW'(32'(rs) * FRAME_WIDTH + 32'(cs));

  logic [6:0] wx, wy;
  assign wx = nidx[0] ? {1'b0, fx} : 7'(s - fx);
  assign wy = nidx[1] ? {1'b0, fy} : 7'(s - fy);
  assign ss = 12'(s) * 12'(s);

  logic [15:0] lim_x, lim_y;
  assign lim_x = 16'(FRAME_WIDTH) * 16'(s);
  assign lim_y = 16'(FRAME_HEIGHT) * 16'(s);

  assign dsamp = 17'($signed(rdata) - $signed(cfg.low_level));
  logic [7:0] gclamp;
  assign gclamp = (dv_quot > 32'(GrayMax)) ? 8'(GrayMax) : dv_quot[7:0];

  // a non-positive difference skips the divider and gives zero
  logic norm_skip;
  assign norm_skip = (state == ST_NORM) && !dv_wait && (dsamp[16] || dsamp == 17'd0);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:
        if (accept && in_ch.cmd == CMD_RENDER) begin
          if ($signed(range) <= 0 ||
              16'(in_ch.out_col) >= lim_x || 16'(in_ch.out_row) >= lim_y)
            state_next = ST_OUT;
          else
            state_next = ST_DIVXY;
        end
      ST_DIVXY:  if (dv_done && phase) state_next = ST_READ;
      ST_READ:   state_next = ST_NORM;
      ST_NORM:   if (dv_done || norm_skip) state_next = ST_ACCUM;
      ST_ACCUM:
        if (!cfg.interp_mode || nidx == 2'd3) state_next =
            cfg.interp_mode ? ST_DIVOUT : ST_OUT;
        else state_next = ST_READ;
      ST_DIVOUT: if (dv_done) state_next = ST_OUT;
      ST_OUT:    state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    dv_start = 1'b0;
    dv_num = '0;
    dv_den = '0;
    case (state)
      ST_DIVXY: begin
        dv_start = !dv_wait;
        dv_num = {24'd0, phase ? y : x};
        dv_den = 17'(s);
      end
      ST_NORM: begin
        dv_start = !dv_wait && !norm_skip;
        dv_num = 32'(dsamp[15:0]) * 32'(GrayMax);
        dv_den = range;
      end
      ST_DIVOUT: begin
        dv_start = !dv_wait;
        dv_num = acc;
        dv_den = 17'(ss);
      end
      default: ;
    endcase
  end

  logic [7:0] nval;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      dv_wait <= 1'b0;
      out_busy <= 1'b0;
    end else begin
      state <= state_next;
      if (dv_start) dv_wait <= 1'b1;
      else if (dv_done) dv_wait <= 1'b0;
      if (state == ST_OUT) out_busy <= 1'b1;
      else if (out_ch.valid && out_ch.ready) out_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        x <= in_ch.out_col;
        y <= in_ch.out_row;
        phase <= 1'b0;
        nidx <= 2'd0;
        acc <= '0;
        gray <= 8'd0;
        if ($signed(range) <= 0) status <= STATUS_RANGE;
        else if (16'(in_ch.out_col) >= lim_x || 16'(in_ch.out_row) >= lim_y)
          status <= STATUS_COORD;
        else status <= STATUS_OK;
      end
      ST_DIVXY:
        if (dv_done) begin
          if (!phase) begin
            vx <= dv_quot[7:0];
            fx <= 6'(x - 8'(dv_quot[7:0] * s));
            phase <= 1'b1;
          end else begin
            vy <= dv_quot[7:0];
            fy <= 6'(y - 8'(dv_quot[7:0] * s));
          end
        end
      ST_NORM: begin
        if (norm_skip) begin
          nval <= 8'd0;
          wgt <= 13'(wx) * 13'(wy);
        end else if (dv_done) begin
          nval <= gclamp;
          wgt <= 13'(wx) * 13'(wy);
        end
      end
      ST_ACCUM: begin
        acc <= acc + 32'(nval) * 32'(wgt);
        nidx <= nidx + 2'd1;
        if (!cfg.interp_mode) gray <= nval;
      end
      ST_DIVOUT:
        if (dv_done) gray <= gclamp;
      default: ;
    endcase
  end

  logic [7:0]  o_gray;
  logic [1:0]  o_status;
  always_ff @(posedge clk) begin
    if (state == ST_OUT) begin
      o_gray <= gray;
      o_status <= status;
    end
  end
  assign out_ch.valid = out_busy;
  assign out_ch.gray = o_gray;
  assign out_ch.status = o_status;
endmodule

/* rtl/core/tfnu_checker.sv */
// Port-level checker for the thermal frame block, bound to the top level.
module tfnu_checker
  import tfnu_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [7:0] gray,
  input logic [1:0] status
);
  a_err_gray: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_OK |-> gray == 8'd0) else $error("gray on error");
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == STATUS_OK || status == STATUS_RANGE || status == STATUS_COORD)
    else $error("bad status");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(gray)) else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready) else $error("accept while result waits");
endmodule

bind thermal_frame_normalize_upscale_top tfnu_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .gray(out_ch.gray), .status(out_ch.status)
);
